FILE: design/triangle_incentre_defines.svh
// ----------------------------------------------------------------------------
// triangle_incentre_defines: assertion macros
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_INCENTRE_DEFINES_SVH
`define TRIANGLE_INCENTRE_DEFINES_SVH
`ifndef ASSERT_OFF
// antecedent implies consequent in the same cycle
`define TIC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define TIC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TIC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define TIC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: design/tic_pkg.sv
// ----------------------------------------------------------------------------
// tic_pkg: triangle incentre package
// Widths, pipeline depths and transaction payload types.
// ----------------------------------------------------------------------------
package tic_pkg;

  localparam int CW       = 32;          // coordinate width
  localparam int LEN_W    = CW + 1;      // side length width
  localparam int SQ_W     = 2 * CW + 1;  // dx^2 + dy^2 width
  localparam int RAD_W    = 2 * LEN_W;   // radicand, padded to even
  localparam int REM_W    = LEN_W + 3;   // sqrt partial remainder
  localparam int PER_W    = LEN_W + 2;   // perimeter width
  localparam int PROD_W   = LEN_W + CW;  // length * coordinate
  localparam int NUM_W    = PROD_W + 2;  // weighted sum
  localparam int SQ_STEPS = LEN_W;       // one root bit per cell
  localparam int DV_STEPS = CW;          // one quotient bit per cell
  // input regs, diff, square, sum, sqrt chain, product, sum, divide, output
  localparam int LAT      = 4 + SQ_STEPS + 2 + DV_STEPS + 1;
  localparam int LEN_AT   = 4 + SQ_STEPS;
  localparam logic [CW-1:0] HALF = {1'b1, {(CW-1){1'b0}}};

  typedef struct packed {
    logic signed [CW-1:0] p0_x;
    logic signed [CW-1:0] p0_y;
    logic signed [CW-1:0] p1_x;
    logic signed [CW-1:0] p1_y;
    logic signed [CW-1:0] p2_x;
    logic signed [CW-1:0] p2_y;
  } in_t;

  typedef struct packed {
    logic signed [CW-1:0] centre_x;
    logic signed [CW-1:0] centre_y;
    logic                 degenerate;
  } out_t;

endpackage

FILE: design/tic_sqrt_cell.sv
// ----------------------------------------------------------------------------
// tic_sqrt_cell: one square root step
// Brings in two radicand bits, tries one root bit, hands on to the next cell.
// ----------------------------------------------------------------------------
module tic_sqrt_cell (
  input  logic                      clk,
  input  logic [tic_pkg::RAD_W-1:0] rad_i,
  input  logic [tic_pkg::REM_W-1:0] rem_i,
  input  logic [tic_pkg::LEN_W-1:0] root_i,
  output logic [tic_pkg::RAD_W-1:0] rad_o,
  output logic [tic_pkg::REM_W-1:0] rem_o,
  output logic [tic_pkg::LEN_W-1:0] root_o
);

  logic [tic_pkg::REM_W-1:0] rem_t;
  logic [tic_pkg::REM_W-1:0] trial;
  logic                      ge;

  // remainder keeps at most REM_W-2 live bits
  always_comb begin
    rem_t = {rem_i[tic_pkg::REM_W-3:0], rad_i[tic_pkg::RAD_W-1 -: 2]};
    trial = {1'b0, root_i, 2'b01};
    ge    = rem_t >= trial;
  end

  always_ff @(posedge clk) begin
    rad_o  <= {rad_i[tic_pkg::RAD_W-3:0], 2'b00};
    rem_o  <= ge ? rem_t - trial : rem_t;
    root_o <= {root_i[tic_pkg::LEN_W-2:0], ge};
  end

endmodule

FILE: design/tic_div_cell.sv
// ----------------------------------------------------------------------------
// tic_div_cell: one restoring division step
// Shifts in one numerator bit and produces one quotient bit.
// ----------------------------------------------------------------------------
module tic_div_cell (
  input  logic                      clk,
  input  logic [tic_pkg::PER_W-1:0] rem_i,
  input  logic [tic_pkg::CW-1:0]    num_i,
  input  logic [tic_pkg::CW-1:0]    q_i,
  input  logic [tic_pkg::PER_W-1:0] d_i,
  output logic [tic_pkg::PER_W-1:0] rem_o,
  output logic [tic_pkg::CW-1:0]    num_o,
  output logic [tic_pkg::CW-1:0]    q_o,
  output logic [tic_pkg::PER_W-1:0] d_o
);

  logic [tic_pkg::PER_W:0] t;
  logic [tic_pkg::PER_W:0] diff;
  logic                    ge;

  // remainder stays below the divisor, so t fits one extra bit
  always_comb begin
    t    = {rem_i, num_i[tic_pkg::CW-1]};
    diff = t - {1'b0, d_i};
    ge   = t >= {1'b0, d_i};
  end

  always_ff @(posedge clk) begin
    rem_o <= ge ? diff[tic_pkg::PER_W-1:0] : t[tic_pkg::PER_W-1:0];
    num_o <= {num_i[tic_pkg::CW-2:0], 1'b0};
    q_o   <= {q_i[tic_pkg::CW-2:0], ge};
    d_o   <= d_i;
  end

endmodule

FILE: design/triangle_incentre.sv
// ----------------------------------------------------------------------------
// triangle_incentre: incenter of one triangle per transaction
// Throughput: one transaction per cycle; busy is always low.
// Depth is set by the 33-cell square root chain and the 32-cell divider chain.
// Reset (rst_n, synchronous) clears the valid line only; transactions in flight
// are dropped. out_valid is a single-cycle strobe the receiver cannot stall.
// ----------------------------------------------------------------------------
`include "triangle_incentre_defines.svh"

module triangle_incentre (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  tic_pkg::in_t  in_data,
  output logic          out_valid,
  output tic_pkg::out_t out_data
);

  localparam int CW  = tic_pkg::CW;
  localparam int SQ  = tic_pkg::SQ_STEPS;
  localparam int DV  = tic_pkg::DV_STEPS;
  localparam int LAT = tic_pkg::LAT;
  localparam int LA  = tic_pkg::LEN_AT;

  logic acc;
  logic [LAT:1] v_r;

  assign busy = 1'b0;
  assign acc  = start && !busy;

  // valid line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[LAT-1:1], acc};
    end
  end
  assign out_valid = v_r[LAT];

  // offset-binary coordinates, carried to the length stage
  logic [CW-1:0] ux_r [LA:1][3];
  logic [CW-1:0] uy_r [LA:1][3];

  always_ff @(posedge clk) begin
    ux_r[1][0] <= in_data.p0_x ^ tic_pkg::HALF;
    uy_r[1][0] <= in_data.p0_y ^ tic_pkg::HALF;
    ux_r[1][1] <= in_data.p1_x ^ tic_pkg::HALF;
    uy_r[1][1] <= in_data.p1_y ^ tic_pkg::HALF;
    ux_r[1][2] <= in_data.p2_x ^ tic_pkg::HALF;
    uy_r[1][2] <= in_data.p2_y ^ tic_pkg::HALF;
    for (int k = 2; k <= LA; k++) begin
      ux_r[k] <= ux_r[k-1];
      uy_r[k] <= uy_r[k-1];
    end
  end

  // side differences, squares and sums; side i is opposite vertex i
  logic [CW-1:0]             dx_r [3];
  logic [CW-1:0]             dy_r [3];
  logic [2*CW-1:0]           sx_r [3];
  logic [2*CW-1:0]           sy_r [3];
  logic [tic_pkg::SQ_W-1:0]  s_r  [3];
  logic [CW-1:0]             ax   [3];
  logic [CW-1:0]             bx   [3];
  logic [CW-1:0]             ay   [3];
  logic [CW-1:0]             by   [3];

  always_comb begin
    ax[0] = ux_r[1][1]; bx[0] = ux_r[1][2]; ay[0] = uy_r[1][1]; by[0] = uy_r[1][2];
    ax[1] = ux_r[1][0]; bx[1] = ux_r[1][2]; ay[1] = uy_r[1][0]; by[1] = uy_r[1][2];
    ax[2] = ux_r[1][0]; bx[2] = ux_r[1][1]; ay[2] = uy_r[1][0]; by[2] = uy_r[1][1];
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dx_r[i] <= (ax[i] >= bx[i]) ? ax[i] - bx[i] : bx[i] - ax[i];
      dy_r[i] <= (ay[i] >= by[i]) ? ay[i] - by[i] : by[i] - ay[i];
      sx_r[i] <= dx_r[i] * dx_r[i];
      sy_r[i] <= dy_r[i] * dy_r[i];
      s_r[i]  <= {1'b0, sx_r[i]} + {1'b0, sy_r[i]};
    end
  end

  // square root chain, three lanes
  logic [tic_pkg::RAD_W-1:0] sq_rad  [3][SQ+1];
  logic [tic_pkg::REM_W-1:0] sq_rem  [3][SQ+1];
  logic [tic_pkg::LEN_W-1:0] sq_root [3][SQ+1];

  for (genvar i = 0; i < 3; i++) begin : g_side
    assign sq_rad[i][0]  = {{(tic_pkg::RAD_W - tic_pkg::SQ_W){1'b0}}, s_r[i]};
    assign sq_rem[i][0]  = '0;
    assign sq_root[i][0] = '0;
    for (genvar k = 0; k < SQ; k++) begin : g_cell
      tic_sqrt_cell u_cell (
        .clk    (clk),
        .rad_i  (sq_rad[i][k]),
        .rem_i  (sq_rem[i][k]),
        .root_i (sq_root[i][k]),
        .rad_o  (sq_rad[i][k+1]),
        .rem_o  (sq_rem[i][k+1]),
        .root_o (sq_root[i][k+1])
      );
    end
  end

  // perimeter and weighted products
  logic [tic_pkg::PER_W-1:0]  per_r;
  logic [tic_pkg::PER_W-1:0]  per2_r;
  logic [tic_pkg::PROD_W-1:0] px_r [3];
  logic [tic_pkg::PROD_W-1:0] py_r [3];
  logic [tic_pkg::NUM_W-1:0]  nx_r;
  logic [tic_pkg::NUM_W-1:0]  ny_r;

  always_ff @(posedge clk) begin
    per_r <= {2'b00, sq_root[0][SQ]} + {2'b00, sq_root[1][SQ]}
           + {2'b00, sq_root[2][SQ]};
    for (int i = 0; i < 3; i++) begin
      px_r[i] <= sq_root[i][SQ] * ux_r[LA][i];
      py_r[i] <= sq_root[i][SQ] * uy_r[LA][i];
    end
    per2_r <= per_r;
    nx_r   <= {2'b00, px_r[0]} + {2'b00, px_r[1]} + {2'b00, px_r[2]};
    ny_r   <= {2'b00, py_r[0]} + {2'b00, py_r[1]} + {2'b00, py_r[2]};
  end

  // vertex zero, kept for the degenerate case
  logic [CW-1:0] p0x_r [LAT-1:LA+1];
  logic [CW-1:0] p0y_r [LAT-1:LA+1];

  always_ff @(posedge clk) begin
    p0x_r[LA+1] <= ux_r[LA][0] ^ tic_pkg::HALF;
    p0y_r[LA+1] <= uy_r[LA][0] ^ tic_pkg::HALF;
    for (int k = LA + 2; k <= LAT - 1; k++) begin
      p0x_r[k] <= p0x_r[k-1];
      p0y_r[k] <= p0y_r[k-1];
    end
  end

  // divider chain, lane 0 is x and lane 1 is y
  logic [tic_pkg::PER_W-1:0] dv_rem [2][DV+1];
  logic [CW-1:0]             dv_num [2][DV+1];
  logic [CW-1:0]             dv_q   [2][DV+1];
  logic [tic_pkg::PER_W-1:0] dv_d   [2][DV+1];

  assign dv_rem[0][0] = nx_r[tic_pkg::NUM_W-1:CW];
  assign dv_num[0][0] = nx_r[CW-1:0];
  assign dv_rem[1][0] = ny_r[tic_pkg::NUM_W-1:CW];
  assign dv_num[1][0] = ny_r[CW-1:0];

  for (genvar j = 0; j < 2; j++) begin : g_axis
    assign dv_q[j][0] = '0;
    assign dv_d[j][0] = per2_r;
    for (genvar k = 0; k < DV; k++) begin : g_cell
      tic_div_cell u_cell (
        .clk   (clk),
        .rem_i (dv_rem[j][k]),
        .num_i (dv_num[j][k]),
        .q_i   (dv_q[j][k]),
        .d_i   (dv_d[j][k]),
        .rem_o (dv_rem[j][k+1]),
        .num_o (dv_num[j][k+1]),
        .q_o   (dv_q[j][k+1]),
        .d_o   (dv_d[j][k+1])
      );
    end
  end

  // rounding toward zero and output register
  logic [CW-1:0] qx;
  logic [CW-1:0] qy;
  logic          degen;

  always_comb begin
    qx = dv_q[0][DV];
    qy = dv_q[1][DV];
    if (qx < tic_pkg::HALF && dv_rem[0][DV] != '0) qx = qx + 1'b1;
    if (qy < tic_pkg::HALF && dv_rem[1][DV] != '0) qy = qy + 1'b1;
    degen = dv_d[0][DV] == '0;
  end

  always_ff @(posedge clk) begin
    out_data.degenerate <= degen;
    out_data.centre_x   <= degen ? p0x_r[LAT-1] : qx ^ tic_pkg::HALF;
    out_data.centre_y   <= degen ? p0y_r[LAT-1] : qy ^ tic_pkg::HALF;
  end

  // degenerate result strobe
  logic deg_v;
  assign deg_v = out_valid && out_data.degenerate;

  `TIC_ASSERT_IMPL(a_lat, clk, rst_n, out_valid, $past(start, LAT))
  `TIC_ASSERT_IMPL(a_degx, clk, rst_n, deg_v, out_data.centre_x == $past(in_data.p0_x, LAT))
  `TIC_ASSERT_IMPL(a_degy, clk, rst_n, deg_v, out_data.centre_y == $past(in_data.p0_y, LAT))
  `TIC_ASSERT_NEXT(a_strobe, clk, rst_n, start, v_r[1])

endmodule
